@@ src/assert_macros.svh @@
// assertion macros shared by the classifier rtl
// no dependencies; clock clk_i and reset rst_ni are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define QATC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define QATC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/qatc_pkg.sv @@
// shared types, codes and character tests of the token classifier
// no dependencies
package qatc_pkg;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  localparam int JOB_FIFO_DEPTH = 4;
  localparam int JOB_PTR_W      = 2;

  typedef enum logic [1:0] {
    KIND_TOKEN  = 2'd0,
    KIND_EOL    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CLS_STRING  = 3'd0,
    CLS_SYMBOL  = 3'd1,
    CLS_EXPR    = 3'd2,
    CLS_NUMBER  = 3'd3,
    CLS_UNKNOWN = 3'd4
  } tok_class_e;

  // all results caused by one input byte
  typedef struct packed {
    logic       tok_vld;
    tok_class_e tok_class;
    logic [7:0] tok_len;
    logic       eol_vld;
    logic       sts_vld;
    logic       unbal;
  } job_t;

  function automatic logic is_letter(logic [7:0] c);
    logic r;
    case (c) inside
      [8'h61:8'h7A], [8'h41:8'h5A]: r = 1'b1;
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_operator(logic [7:0] c);
    logic r;
    case (c) inside
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3D, 8'h3E, 8'h3C, 8'h21: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    logic r;
    case (c) inside
      [8'h30:8'h39]: r = 1'b1;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ src/quote_aware_token_classifier_unit.sv @@
// top level of the quote-aware token classifier
// depends on qatc_pkg, qatc_front, qatc_fifo, qatc_back
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------------
//  in      | input     | in_valid_i / in_ready_o  | char_byte_i, end_mark_i
//  out     | output    | out_valid_o / out_ready_i| result_kind_o, token_class_o,
//          |           |                         | token_length_o, quotes_unbalanced_o,
//          |           |                         | last_result_o
//
// one byte is taken each cycle while the job queue (4 deep) has room
// each byte makes 0..3 result words; the back end sends one word per cycle
// while the output is not stalled, and the queue soaks up bursts
// with an empty queue the first result word passes the job queue, then the output register
// reset clears quote parity, token flags and the queue; no clearing pass
module quote_aware_token_classifier_unit #(
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       end_mark_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [2:0] token_class_o,
  output logic [7:0] token_length_o,
  output logic       quotes_unbalanced_o,
  output logic       last_result_o
);

  logic           acc;
  logic           push, full, pop, head_vld;
  qatc_pkg::job_t job, head;

  qatc_pkg::kind_e      kind;
  qatc_pkg::tok_class_e cls;

  // accept whenever the queue can hold the job this byte may create
  assign in_ready_o = !full;
  assign acc        = in_valid_i && in_ready_o;

  // front: parity, token flags, line state
  qatc_front #(
    .MaxTokenLen (MAX_TOKEN_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .char_byte_i (char_byte_i),
    .end_mark_i  (end_mark_i),
    .push_o      (push),
    .job_o       (job)
  );

  // queue of pending jobs, lets either side stall on its own
  qatc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (job),
    .full_o     (full),
    .pop_i      (pop),
    .head_vld_o (head_vld),
    .head_o     (head)
  );

  // back: one result word per cycle into the output register unless the output stalls
  qatc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind),
    .class_o     (cls),
    .len_o       (token_length_o),
    .unbal_o     (quotes_unbalanced_o),
    .last_o      (last_result_o)
  );

  assign result_kind_o = kind;
  assign token_class_o = cls;

endmodule

@@ src/qatc_front.sv @@
// front end: takes bytes, tracks quote parity and token flags, builds jobs
// depends on qatc_pkg
module qatc_front #(
  parameter int MaxTokenLen = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [7:0]       char_byte_i,
  input  logic             end_mark_i,
  output logic             push_o,
  output qatc_pkg::job_t   job_o
);

  localparam int CntW = ($clog2(MaxTokenLen + 3) > 8) ? $clog2(MaxTokenLen + 3) : 8;
  localparam logic [CntW-1:0] CntSat = CntW'(MaxTokenLen + 2);
  localparam logic [CntW-1:0] LenMax = CntW'(MaxTokenLen);
  localparam logic [CntW-1:0] Len255 = CntW'(255);
  localparam logic [CntW-1:0] CntTwo = CntW'(2);

  logic            parity_q, parity_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            first_q, first_d, last_q, last_d;
  logic            letters_q, letters_d, ops_q, ops_d, digits_q, digits_d;
  logic            line_q, line_d;

  logic            is_q, is_nl, is_sp, par_nx;
  logic            brk_nl, brk_sp, flush;
  logic [CntW-1:0] len_raw, len_cap;
  qatc_pkg::tok_class_e cls;

  always_comb begin
    is_q   = (char_byte_i == qatc_pkg::CHAR_QUOTE);
    is_nl  = (char_byte_i == qatc_pkg::CHAR_NL);
    is_sp  = (char_byte_i == qatc_pkg::CHAR_SP);
    par_nx = parity_q ^ is_q;
    brk_nl = !end_mark_i && is_nl && !par_nx;
    brk_sp = !end_mark_i && is_sp && !par_nx;
    flush  = end_mark_i || brk_nl || brk_sp;

    if (first_q && last_q) begin
      cls     = qatc_pkg::CLS_STRING;
      len_raw = (cnt_q >= CntTwo) ? cnt_q - CntTwo : '0;
    end else begin
      len_raw = cnt_q;
      if (letters_q)     cls = qatc_pkg::CLS_SYMBOL;
      else if (ops_q)    cls = qatc_pkg::CLS_EXPR;
      else if (digits_q) cls = qatc_pkg::CLS_NUMBER;
      else               cls = qatc_pkg::CLS_UNKNOWN;
    end
    len_cap = (len_raw > LenMax) ? LenMax : len_raw;

    job_o.tok_vld   = flush && (cnt_q != '0);
    job_o.tok_class = cls;
    job_o.tok_len   = (len_cap > Len255) ? 8'hFF : len_cap[7:0];
    job_o.eol_vld   = (end_mark_i || brk_nl) && line_q;
    job_o.sts_vld   = end_mark_i;
    job_o.unbal     = end_mark_i && parity_q;
    push_o = acc_i && (job_o.tok_vld || job_o.eol_vld || job_o.sts_vld);
  end

  always_comb begin
    parity_d  = parity_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    last_d    = last_q;
    letters_d = letters_q;
    ops_d     = ops_q;
    digits_d  = digits_q;
    line_d    = line_q;
    if (acc_i) begin
      parity_d = par_nx;
      if (flush) begin
        cnt_d     = '0;
        first_d   = 1'b0;
        last_d    = 1'b0;
        letters_d = 1'b1;
        ops_d     = 1'b1;
        digits_d  = 1'b1;
      end
      if (end_mark_i) begin
        parity_d = 1'b0;
        line_d   = 1'b0;
      end else if (brk_nl) begin
        line_d = 1'b0;
      end else if (brk_sp) begin
        line_d = 1'b1;
      end else begin
        line_d = 1'b1;
        if (cnt_q == '0) first_d = is_q;
        last_d = is_q;
        if (cnt_q < CntSat) cnt_d = cnt_q + CntW'(1);
        if (!qatc_pkg::is_letter(char_byte_i))   letters_d = 1'b0;
        if (!qatc_pkg::is_operator(char_byte_i)) ops_d     = 1'b0;
        if (!qatc_pkg::is_digit(char_byte_i))    digits_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q  <= 1'b0;
      cnt_q     <= '0;
      first_q   <= 1'b0;
      last_q    <= 1'b0;
      letters_q <= 1'b1;
      ops_q     <= 1'b1;
      digits_q  <= 1'b1;
      line_q    <= 1'b0;
    end else begin
      parity_q  <= parity_d;
      cnt_q     <= cnt_d;
      first_q   <= first_d;
      last_q    <= last_d;
      letters_q <= letters_d;
      ops_q     <= ops_d;
      digits_q  <= digits_d;
      line_q    <= line_d;
    end
  end

endmodule

@@ src/qatc_fifo.sv @@
// small job queue between front and back ends
// depends on qatc_pkg and assert_macros.svh
`include "assert_macros.svh"
module qatc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qatc_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_vld_o,
  output qatc_pkg::job_t head_o
);

  localparam int PtrW = qatc_pkg::JOB_PTR_W;
  localparam logic [PtrW:0] Depth = (PtrW + 1)'(qatc_pkg::JOB_FIFO_DEPTH);

  qatc_pkg::job_t slot_q [qatc_pkg::JOB_FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == Depth);
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PtrW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + (PtrW + 1)'(push_i) - (PtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `QATC_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= Depth, "job queue count beyond depth")
  `QATC_ASSERT(a_no_push_full, full_o |-> !push_i, "push into full job queue")
  `QATC_ASSERT(a_no_pop_empty, pop_i |-> head_vld_o, "pop from empty job queue")

endmodule

@@ src/qatc_back.sv @@
// back end: splits each queued job into result words behind an output register
// depends on qatc_pkg and assert_macros.svh
`include "assert_macros.svh"
module qatc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_vld_i,
  input  qatc_pkg::job_t       head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qatc_pkg::kind_e      kind_o,
  output qatc_pkg::tok_class_e class_o,
  output logic [7:0]           len_o,
  output logic                 unbal_o,
  output logic                 last_o
);

  // bit 0 token, bit 1 end of line, bit 2 status
  logic [2:0] done_q, done_d;
  logic [2:0] pending, sel, rest;
  logic       load, is_last;

  logic                 vld_q, vld_d;
  qatc_pkg::kind_e      kind_q, kind_d;
  qatc_pkg::tok_class_e cls_q, cls_d;
  logic [7:0]           len_q, len_d;
  logic                 unbal_q, unbal_d, last_q, last_d;

  always_comb begin
    pending = {head_i.sts_vld, head_i.eol_vld, head_i.tok_vld} & ~done_q;
    sel     = pending & (~pending + 3'd1);
    rest    = pending & ~sel;
    is_last = (rest == 3'b000);
    load    = head_vld_i && (!vld_q || out_ready_i);
    pop_o   = load && is_last;

    done_d  = done_q;
    vld_d   = vld_q;
    kind_d  = kind_q;
    cls_d   = cls_q;
    len_d   = len_q;
    unbal_d = unbal_q;
    last_d  = last_q;
    if (out_ready_i) vld_d = 1'b0;
    if (load) begin
      vld_d   = 1'b1;
      last_d  = is_last;
      done_d  = is_last ? 3'b000 : (done_q | sel);
      cls_d   = qatc_pkg::CLS_STRING;
      len_d   = 8'h00;
      unbal_d = 1'b0;
      if (sel[0]) begin
        kind_d = qatc_pkg::KIND_TOKEN;
        cls_d  = head_i.tok_class;
        len_d  = head_i.tok_len;
      end else if (sel[1]) begin
        kind_d = qatc_pkg::KIND_EOL;
      end else begin
        kind_d  = qatc_pkg::KIND_STATUS;
        unbal_d = head_i.unbal;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 3'b000;
      vld_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    cls_q   <= cls_d;
    len_q   <= len_d;
    unbal_q <= unbal_d;
    last_q  <= last_d;
  end

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign class_o     = cls_q;
  assign len_o       = len_q;
  assign unbal_o     = unbal_q;
  assign last_o      = last_q;

  `QATC_ASSERT(a_head_pending, head_vld_i |-> pending != 3'b000, "queued job with nothing left")
  `QATC_ASSERT(a_status_last, (vld_q && kind_q == qatc_pkg::KIND_STATUS) |-> last_q, "status word not last")
  `QATC_ASSERT(a_done_clear, !head_vld_i |-> done_q == 3'b000, "progress bits set with no job")

endmodule
